FILE: src/fat_pkg.sv
// Shared types, widths and the arctangent table of the fiducial alignment transform.
package fat_pkg;

    localparam int XW = 64;   // CORDIC x/y datapath width
    localparam int ZW = 36;   // CORDIC angle accumulator width, Q24 degrees
    localparam int MW = 34;   // multiplier operand width

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cmode_t;

    // atan(2^-i) in Q24 degrees
    function automatic logic [29:0] atan_q24(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            5'd24: v = 30'd57;
            5'd25: v = 30'd29;
            5'd26: v = 30'd14;
            5'd27: v = 30'd7;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/fat_mul.sv
// Shared signed multiplier with registered product.
module fat_mul
    import fat_pkg::*;
(
    input  logic                   aclk,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] p
);

    logic signed [2*MW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: src/fat_cordic.sv
// One CORDIC micro-rotation, shared by vectoring and rotation passes.
module fat_cordic
    import fat_pkg::*;
(
    input  cmode_t                mode,
    input  logic [4:0]            idx,
    input  logic signed [XW-1:0]  x_i,
    input  logic signed [XW-1:0]  y_i,
    input  logic signed [ZW-1:0]  z_i,
    output logic signed [XW-1:0]  x_o,
    output logic signed [XW-1:0]  y_o,
    output logic signed [ZW-1:0]  z_o
);

    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 ccw;

    assign xs = x_i >>> idx;
    assign ys = y_i >>> idx;
    assign at = $signed({{(ZW-30){1'b0}}, atan_q24(idx)});
    // vectoring drives y to zero, rotation drives z to zero
    assign ccw = (mode == CM_VECTOR) ? (y_i <= 0) : (z_i >= 0);

    always_comb begin
        if (ccw) begin
            x_o = x_i - ys;
            y_o = y_i + xs;
            z_o = z_i - at;
        end else begin
            x_o = x_i + ys;
            y_o = y_i - xs;
            z_o = z_i + at;
        end
    end

endmodule

FILE: src/fiducial_alignment_transform_unit.sv
// Top level: configuration, fiducial offset store, sequencer and output register.
// Report transaction: 4 multiplies on the shared unit between accept and result valid.
// Correction with 0 or 1 fiducial follows the same path. With 2 fiducials the
// dot products, normalisation, CORDIC vectoring and rotation passes and the rotate multiplies
// run in turn on the single CORDIC step unit and multiplier. One transaction in flight;
// s_tready is high only when idle, so a new accept waits until the result is taken.
// aresetn (synchronous, active low) clears control, configuration and the offset store.
module fiducial_alignment_transform_unit
    import fat_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fid_index, found_x, found_y, image_width, image_height, pos_x, pos_y, zero pad
    input  logic [127:0] s_tdata,
    // action
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // offset_x, offset_y, reject_x, reject_y, adjusted_x, adjusted_y, angle, zero pad
    output logic [111:0] m_tdata
);

    localparam int CW = $clog2(CORDIC_STEPS + 1);
    localparam logic [2:0] R_FID = 3'd0, R_SCX = 3'd1, R_SCY = 3'd2, R_R0X = 3'd3,
                           R_R0Y = 3'd4, R_R1X = 3'd5, R_R1Y = 3'd6;
    localparam logic signed [55:0] REJ_LIM = 56'sd23068672000;
    localparam logic signed [XW-1:0] LIM50 = 64'sd1125899906842624;
    localparam logic signed [ZW-1:0] DEG90 = 36'sd1509949440;
    localparam logic signed [XW-1:0] INV_GAIN = 64'sd652032874;
    localparam logic signed [16:0] ANG_LIM = 17'sd46080;

    typedef enum logic [3:0] {
        ST_IDLE, ST_UMUL, ST_BRANCH, ST_PTS, ST_VCHK, ST_DOT, ST_SUM, ST_NORM,
        ST_PRE, ST_VITER, ST_ANG, ST_RITER, ST_RMUL, ST_FIN, ST_OUT
    } state_t;

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607) return 24'sd8388607;
        if (v < -40'sd8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // shift right by 16 with truncation toward zero
    function automatic logic signed [19:0] trunc16(input logic signed [55:0] v);
        logic signed [55:0] t;
        t = v + (v[55] ? 56'sd65535 : 56'sd0);
        return t[35:16];
    endfunction

    function automatic logic signed [25:0] trunc20(input logic signed [55:0] v);
        logic signed [55:0] t;
        t = v + (v[55] ? 56'sd1048575 : 56'sd0);
        return t[45:20];
    endfunction

    function automatic logic small50(input logic signed [XW-1:0] v);
        return (v < LIM50) && (v > -LIM50);
    endfunction

    // configuration
    logic [1:0]         fid_count_reg;
    logic [31:0]        scale_x_reg, scale_y_reg;
    logic signed [23:0] ref0_x_reg, ref0_y_reg, ref1_x_reg, ref1_y_reg;

    // offset store, 1/16 pixel
    logic signed [21:0] pix_x_reg [2];
    logic signed [21:0] pix_y_reg [2];

    state_t             state_reg, state_next;
    logic [2:0]         mc_reg, mc_next;
    logic [CW-1:0]      it_reg, it_next;
    logic               act_reg, act_next;
    logic               fid_reg, fid_next;
    logic signed [23:0] px_reg, px_next, py_reg, py_next;
    logic signed [55:0] u_reg [4];
    logic signed [55:0] u_next [4];
    logic [3:0]         rj_reg, rj_next;
    logic signed [25:0] r0x_reg, r0x_next, r0y_reg, r0y_next;
    logic signed [25:0] e1x_reg, e1x_next, e1y_reg, e1y_next;
    logic signed [25:0] f1x_reg, f1x_next, f1y_reg, f1y_next;
    logic signed [26:0] v1x_reg, v1x_next, v1y_reg, v1y_next;
    logic signed [26:0] v2x_reg, v2x_next, v2y_reg, v2y_next;
    logic signed [63:0] pr_reg [4];
    logic signed [63:0] pr_next [4];
    logic signed [XW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic signed [16:0] ang_reg, ang_next;
    logic signed [19:0] o_offx_reg, o_offx_next, o_offy_reg, o_offy_next;
    logic               o_rx_reg, o_rx_next, o_ry_reg, o_ry_next;
    logic signed [23:0] o_adjx_reg, o_adjx_next, o_adjy_reg, o_adjy_next;
    logic signed [16:0] o_ang_reg, o_ang_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // shared units
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    cmode_t                 cmode;
    logic signed [XW-1:0]   cu_x, cu_y;
    logic signed [ZW-1:0]   cu_z;

    fat_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    fat_cordic u_cordic (
        .mode (cmode),
        .idx  (5'(it_reg)),
        .x_i  (cx_reg),
        .y_i  (cy_reg),
        .z_i  (cz_reg),
        .x_o  (cu_x),
        .y_o  (cu_y),
        .z_o  (cu_z)
    );

    // input fields
    logic               in_fid;
    logic [19:0]        in_fx, in_fy;
    logic [15:0]        in_w, in_h;
    logic signed [23:0] in_px, in_py;
    logic               in_acc;

    assign in_fid = s_tdata[0];
    assign in_fx  = s_tdata[20:1];
    assign in_fy  = s_tdata[40:21];
    assign in_w   = s_tdata[56:41];
    assign in_h   = s_tdata[72:57];
    assign in_px  = s_tdata[96:73];
    assign in_py  = s_tdata[120:97];
    assign in_acc = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, o_ang_reg, o_adjy_reg, o_adjx_reg, o_ry_reg, o_rx_reg,
                       o_offy_reg, o_offx_reg};

    // position relative to taught fiducial 0, 1/16 um
    logic signed [28:0] dx, dy;
    assign dx = 29'(px_reg) - (29'(ref0_x_reg) <<< 4);
    assign dy = 29'(py_reg) - (29'(ref0_y_reg) <<< 4);

    logic [1:0] op_sel, cap_sel;
    assign op_sel  = mc_reg[1:0];
    assign cap_sel = 2'(mc_reg - 3'd1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_UMUL: begin
                case (op_sel)
                    2'd0: begin mul_a = MW'(pix_x_reg[0]); mul_b = {2'b0, scale_x_reg}; end
                    2'd1: begin mul_a = MW'(pix_y_reg[0]); mul_b = {2'b0, scale_y_reg}; end
                    2'd2: begin mul_a = MW'(pix_x_reg[1]); mul_b = {2'b0, scale_x_reg}; end
                    default: begin mul_a = MW'(pix_y_reg[1]); mul_b = {2'b0, scale_y_reg}; end
                endcase
            end
            ST_DOT: begin
                case (op_sel)
                    2'd0: begin mul_a = MW'(v1x_reg); mul_b = MW'(v2x_reg); end
                    2'd1: begin mul_a = MW'(v1y_reg); mul_b = MW'(v2y_reg); end
                    2'd2: begin mul_a = MW'(v1x_reg); mul_b = MW'(v2y_reg); end
                    default: begin mul_a = MW'(v1y_reg); mul_b = MW'(v2x_reg); end
                endcase
            end
            ST_RMUL: begin
                case (op_sel)
                    2'd0: begin mul_a = MW'(dx); mul_b = cx_reg[MW-1:0]; end
                    2'd1: begin mul_a = MW'(dy); mul_b = cy_reg[MW-1:0]; end
                    2'd2: begin mul_a = MW'(dx); mul_b = cy_reg[MW-1:0]; end
                    default: begin mul_a = MW'(dy); mul_b = cx_reg[MW-1:0]; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cmode = (state_reg == ST_RITER) ? CM_ROTATE : CM_VECTOR;

    logic signed [55:0] cap_u;
    logic               cap_rej;
    logic signed [55:0] s_r0x, s_r0y, s_e1x, s_e1y, s_f1x, s_f1y;
    logic signed [ZW-1:0] z_rnd;
    logic signed [19:0] a_full;
    logic signed [16:0] a_clamp;
    logic signed [ZW-1:0] z_rot;
    logic signed [63:0] fx_sum, fy_sum;
    logic signed [39:0] fx_pos, fy_pos;
    logic signed [39:0] sh_x, sh_y;

    assign cap_u   = mul_p[55:0];
    assign cap_rej = (cap_u > REJ_LIM) || (cap_u < -REJ_LIM);

    assign s_r0x = (56'(ref0_x_reg) <<< 20) + u_reg[0];
    assign s_r0y = (56'(ref0_y_reg) <<< 20) + u_reg[1];
    assign s_e1x = (56'(ref1_x_reg) <<< 20) + u_reg[0];
    assign s_e1y = (56'(ref1_y_reg) <<< 20) + u_reg[1];
    assign s_f1x = (56'(ref1_x_reg) <<< 20) + u_reg[2];
    assign s_f1y = (56'(ref1_y_reg) <<< 20) + u_reg[3];

    // round half up to 1/256 degree, clamp
    assign z_rnd   = cz_reg + 36'sd32768;
    assign a_full  = z_rnd[35:16];
    assign a_clamp = (a_full > 20'sd46080) ? ANG_LIM :
                     (a_full < -20'sd46080) ? -ANG_LIM : a_full[16:0];
    assign z_rot   = ZW'(a_clamp) <<< 16;

    assign fx_sum = pr_reg[0] - pr_reg[1] + 64'sd536870912;
    assign fy_sum = pr_reg[2] + pr_reg[3] + 64'sd536870912;
    assign fx_pos = 40'($signed(fx_sum[63:30])) + (40'(ref0_x_reg) <<< 4);
    assign fy_pos = 40'($signed(fy_sum[63:30])) + (40'(ref0_y_reg) <<< 4);

    assign sh_x = 40'(px_reg) + 40'(trunc16(u_reg[0]));
    assign sh_y = 40'(py_reg) + 40'(trunc16(u_reg[1]));

    always_comb begin
        state_next    = state_reg;
        mc_next       = mc_reg;
        it_next       = it_reg;
        act_next      = act_reg;
        fid_next      = fid_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        u_next        = u_reg;
        rj_next       = rj_reg;
        r0x_next      = r0x_reg;
        r0y_next      = r0y_reg;
        e1x_next      = e1x_reg;
        e1y_next      = e1y_reg;
        f1x_next      = f1x_reg;
        f1y_next      = f1y_reg;
        v1x_next      = v1x_reg;
        v1y_next      = v1y_reg;
        v2x_next      = v2x_reg;
        v2y_next      = v2y_reg;
        pr_next       = pr_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        ang_next      = ang_reg;
        o_offx_next   = o_offx_reg;
        o_offy_next   = o_offy_reg;
        o_rx_next     = o_rx_reg;
        o_ry_next     = o_ry_reg;
        o_adjx_next   = o_adjx_reg;
        o_adjy_next   = o_adjy_reg;
        o_ang_next    = o_ang_reg;
        m_tvalid_next = m_tvalid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    act_next   = s_tuser;
                    fid_next   = in_fid;
                    px_next    = in_px;
                    py_next    = in_py;
                    mc_next    = '0;
                    state_next = ST_UMUL;
                end
            end
            ST_UMUL: begin
                if (mc_reg != 3'd0) begin
                    u_next[cap_sel]  = cap_rej ? 56'sd0 : cap_u;
                    rj_next[cap_sel] = cap_rej;
                end
                mc_next = mc_reg + 3'd1;
                if (mc_reg == 3'd4) begin
                    state_next = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                o_offx_next = '0;
                o_offy_next = '0;
                o_rx_next   = 1'b0;
                o_ry_next   = 1'b0;
                o_adjx_next = px_reg;
                o_adjy_next = py_reg;
                o_ang_next  = '0;
                state_next  = ST_OUT;
                if (!act_reg) begin
                    o_offx_next = trunc16(u_reg[{fid_reg, 1'b0}]);
                    o_offy_next = trunc16(u_reg[{fid_reg, 1'b1}]);
                    o_rx_next   = rj_reg[{fid_reg, 1'b0}];
                    o_ry_next   = rj_reg[{fid_reg, 1'b1}];
                    o_adjx_next = '0;
                    o_adjy_next = '0;
                end else if (fid_count_reg == 2'd1) begin
                    o_adjx_next = sat24(sh_x);
                    o_adjy_next = sat24(sh_y);
                end else if (fid_count_reg == 2'd2) begin
                    state_next = ST_PTS;
                end
            end
            ST_PTS: begin
                r0x_next   = trunc20(s_r0x);
                r0y_next   = trunc20(s_r0y);
                e1x_next   = trunc20(s_e1x);
                e1y_next   = trunc20(s_e1y);
                f1x_next   = trunc20(s_f1x);
                f1y_next   = trunc20(s_f1y);
                state_next = ST_VCHK;
            end
            ST_VCHK: begin
                v1x_next = 27'(e1x_reg) - 27'(r0x_reg);
                v1y_next = 27'(e1y_reg) - 27'(r0y_reg);
                v2x_next = 27'(f1x_reg) - 27'(r0x_reg);
                v2y_next = 27'(f1y_reg) - 27'(r0y_reg);
                mc_next  = '0;
                // a zero vector leaves the position unrotated
                if (((e1x_reg == r0x_reg) && (e1y_reg == r0y_reg)) ||
                    ((f1x_reg == r0x_reg) && (f1y_reg == r0y_reg))) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (mc_reg != 3'd0) begin
                    pr_next[cap_sel] = mul_p[63:0];
                end
                mc_next = mc_reg + 3'd1;
                if (mc_reg == 3'd4) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cx_next    = pr_reg[0] + pr_reg[1];
                cy_next    = pr_reg[2] - pr_reg[3];
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (small50(cx_reg) && small50(cy_reg)) begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end else begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                cz_next = '0;
                it_next = '0;
                if (cx_reg < 0) begin
                    if (cy_reg >= 0) begin
                        cx_next = cy_reg;
                        cy_next = -cx_reg;
                        cz_next = DEG90;
                    end else begin
                        cx_next = -cy_reg;
                        cy_next = cx_reg;
                        cz_next = -DEG90;
                    end
                end
                state_next = ST_VITER;
            end
            ST_VITER: begin
                cx_next = cu_x;
                cy_next = cu_y;
                cz_next = cu_z;
                it_next = it_reg + 1'b1;
                if (it_reg == CW'(CORDIC_STEPS - 1)) begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG: begin
                ang_next = a_clamp;
                it_next  = '0;
                if (z_rot > DEG90) begin
                    cx_next = '0;
                    cy_next = INV_GAIN;
                    cz_next = z_rot - DEG90;
                end else if (z_rot < -DEG90) begin
                    cx_next = '0;
                    cy_next = -INV_GAIN;
                    cz_next = z_rot + DEG90;
                end else begin
                    cx_next = INV_GAIN;
                    cy_next = '0;
                    cz_next = z_rot;
                end
                state_next = ST_RITER;
            end
            ST_RITER: begin
                cx_next = cu_x;
                cy_next = cu_y;
                cz_next = cu_z;
                it_next = it_reg + 1'b1;
                mc_next = '0;
                if (it_reg == CW'(CORDIC_STEPS - 1)) begin
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL: begin
                if (mc_reg != 3'd0) begin
                    pr_next[cap_sel] = mul_p[63:0];
                end
                mc_next = mc_reg + 3'd1;
                if (mc_reg == 3'd4) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                o_adjx_next = sat24(fx_pos);
                o_adjy_next = sat24(fy_pos);
                o_ang_next  = ang_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid_next = 1'b1;
                if (m_tvalid_reg && m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mc_reg        <= '0;
            it_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
            fid_count_reg <= 2'd0;
            scale_x_reg   <= 32'd655360000;
            scale_y_reg   <= 32'd655360000;
            ref0_x_reg    <= '0;
            ref0_y_reg    <= '0;
            ref1_x_reg    <= '0;
            ref1_y_reg    <= '0;
            pix_x_reg[0]  <= '0;
            pix_x_reg[1]  <= '0;
            pix_y_reg[0]  <= '0;
            pix_y_reg[1]  <= '0;
        end else begin
            state_reg    <= state_next;
            mc_reg       <= mc_next;
            it_reg       <= it_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    R_FID: fid_count_reg <= cfg_wdata[1:0];
                    R_SCX: scale_x_reg   <= cfg_wdata;
                    R_SCY: scale_y_reg   <= cfg_wdata;
                    R_R0X: ref0_x_reg    <= cfg_wdata[23:0];
                    R_R0Y: ref0_y_reg    <= cfg_wdata[23:0];
                    R_R1X: ref1_x_reg    <= cfg_wdata[23:0];
                    R_R1Y: ref1_y_reg    <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (in_acc && !s_tuser) begin
                pix_x_reg[in_fid] <= $signed({2'b0, in_fx}) - $signed({3'b0, in_w[15:1], 4'b0});
                pix_y_reg[in_fid] <= $signed({2'b0, in_fy}) - $signed({3'b0, in_h[15:1], 4'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        fid_reg    <= fid_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        u_reg      <= u_next;
        rj_reg     <= rj_next;
        r0x_reg    <= r0x_next;
        r0y_reg    <= r0y_next;
        e1x_reg    <= e1x_next;
        e1y_reg    <= e1y_next;
        f1x_reg    <= f1x_next;
        f1y_reg    <= f1y_next;
        v1x_reg    <= v1x_next;
        v1y_reg    <= v1y_next;
        v2x_reg    <= v2x_next;
        v2y_reg    <= v2y_next;
        pr_reg     <= pr_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        ang_reg    <= ang_next;
        o_offx_reg <= o_offx_next;
        o_offy_reg <= o_offy_next;
        o_rx_reg   <= o_rx_next;
        o_ry_reg   <= o_ry_next;
        o_adjx_reg <= o_adjx_next;
        o_adjy_reg <= o_adjy_next;
        o_ang_reg  <= o_ang_next;
    end

endmodule
